/* design/wireframe_edge_projector_assert.svh */
// Assertion macros for the wireframe edge projector.
// Used by modules that check their own control sequencing; needs clk and rst in scope.
`ifndef WIREFRAME_EDGE_PROJECTOR_ASSERT_SVH
`define WIREFRAME_EDGE_PROJECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset
`define WEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included
`define WEP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WEP_ASSERT(label, prop, msg)
`define WEP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* design/wep_pkg.sv */
// Shared types and constants for the wireframe edge projector.
// No dependencies; imported by the controller, datapath and top level.
package wep_pkg;

  // Item modes
  localparam logic [1:0] MODE_LOAD_POINT  = 2'd0;
  localparam logic [1:0] MODE_LOAD_MATRIX = 2'd1;
  localparam logic [1:0] MODE_DRAW_EDGE   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z      = 3'd4;

  localparam logic [12:0] WINDOW_WIDTH_RESET  = 13'd1680;
  localparam logic [12:0] WINDOW_HEIGHT_RESET = 13'd1050;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;       // latch input item
    logic       store_point;   // write point stores
    logic       store_matrix;  // write matrix entry
    logic       rd_point;      // read point stores
    logic       ep;            // endpoint: 0 start, 1 end
    logic       mac_step;      // issue one matrix product
    logic [3:0] mac_k;         // matrix entry of this product
    logic       div_start;     // start w division
    logic       axis;          // 0 x, 1 y
    logic       pix_mul;       // viewport multiply
    logic       pix_store;     // round, saturate, store pixel
    logic       emit;          // present the line
  } wep_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       idx1_ok;
    logic       idx2_ok;
    logic       reject;
    logic       div_busy;
    logic       div_done;
  } wep_status_t;

endpackage

/* design/wep_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/wep_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// No dependencies; used by the datapath for the w divisions.
module wep_divider #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic signed [DW-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic signed [NW:0]   quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] dsr;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          neg;

  logic [DW:0]   rem_sh;
  logic          qbit;

  // One restoring step
  always_comb begin
    rem_sh = {rem[DW-1:0], quo[NW-1]};
    qbit   = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        quo  <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
        dsr  <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
        rem  <= '0;
        neg  <= dividend[NW-1] ^ divisor[DW-1];
      end else if (busy) begin
        rem <= qbit ? (rem_sh - {1'b0, dsr}) : rem_sh;
        quo <= {quo[NW-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply sign to magnitude
  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
endmodule

/* design/wep_datapath.sv */
// Datapath: configuration, point stores, matrix, shared multiplier, divider, pixel stage.
// Depends on wep_pkg, wep_ram and wep_divider.
module wep_datapath #(
  parameter int MAX_POINTS      = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wep_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [1:0]                        mode,
  input  logic [7:0]                        first_index,
  input  logic [7:0]                        second_index,
  input  logic signed [31:0]                coord_x,
  input  logic signed [31:0]                coord_y,
  input  logic signed [31:0]                coord_z,
  input  logic signed [31:0]                matrix_value,
  input  logic [31:0]                       edge_color,
  input  wep_pkg::wep_cmd_t                 cmd,
  output wep_pkg::wep_status_t              status,
  output logic                              line_valid,
  output logic signed [15:0]                start_x,
  output logic signed [15:0]                start_y,
  output logic signed [15:0]                end_x,
  output logic signed [15:0]                end_y,
  output logic [31:0]                       line_color
);
  import wep_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = 32 + F;
  localparam int QW = NW + 1;
  localparam int TW = QW + 1;
  localparam int PW = TW + 14;
  localparam logic signed [31:0] ONE = 32'sd1 <<< F;
  localparam logic signed [PW-1:0] BIAS = PW'((64'sd1 <<< (F + 1)) - 64'sd1);
  localparam logic signed [PW-1:0] PIX_MAX = PW'(32767);
  localparam logic signed [PW-1:0] PIX_MIN = -PIX_MAX - PW'(1);
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -S32_MAX - 64'sd1;

  // Configuration registers
  logic [12:0]        win_w, win_h;
  logic signed [31:0] off_x, off_y, off_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_w <= WINDOW_WIDTH_RESET;
      win_h <= WINDOW_HEIGHT_RESET;
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_WIDTH:  win_w <= cfg_data[12:0];
        CFG_WINDOW_HEIGHT: win_h <= cfg_data[12:0];
        CFG_OFFSET_X:      off_x <= cfg_data;
        CFG_OFFSET_Y:      off_y <= cfg_data;
        CFG_OFFSET_Z:      off_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured item
  logic [1:0]         it_mode;
  logic [7:0]         it_i1, it_i2;
  logic signed [31:0] it_x, it_y, it_z, it_mval;
  logic [31:0]        it_color;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode  <= mode;
      it_i1    <= first_index;
      it_i2    <= second_index;
      it_x     <= coord_x;
      it_y     <= coord_y;
      it_z     <= coord_z;
      it_mval  <= matrix_value;
      it_color <= edge_color;
    end
  end

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  // Offset add on load
  logic signed [32:0] sum_x, sum_y, sum_z;
  assign sum_x = 33'(it_x) + 33'(off_x);
  assign sum_y = 33'(it_y) + 33'(off_y);
  assign sum_z = 33'(it_z) + 33'(off_z);

  // Point stores
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] px, py, pz;
  assign waddr = AW'(it_i1);
  assign raddr = AW'(cmd.ep ? it_i2 : it_i1);

  wep_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(cmd.store_point), .waddr(waddr), .wdata(sat33(sum_x)),
    .re(cmd.rd_point), .raddr(raddr), .rdata(px)
  );
  wep_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(cmd.store_point), .waddr(waddr), .wdata(sat33(sum_y)),
    .re(cmd.rd_point), .raddr(raddr), .rdata(py)
  );
  wep_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_z (
    .clk(clk), .we(cmd.store_point), .waddr(waddr), .wdata(sat33(sum_z)),
    .re(cmd.rd_point), .raddr(raddr), .rdata(pz)
  );

  // Matrix, identity after reset
  logic signed [31:0] mat [16];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= (i % 5 == 0) ? ONE : 32'sd0;
      end
    end else if (cmd.store_matrix && it_i1 < 8'd16) begin
      mat[it_i1[3:0]] <= it_mval;
    end
  end

  // Shared multiplier: one matrix entry times x, y, z or one per cycle
  logic signed [31:0] opnd;
  logic signed [63:0] prod;
  logic               prod_v;
  logic [3:0]         prod_k;

  always_comb begin
    case (cmd.mac_k[1:0])
      2'd0:    opnd = px;
      2'd1:    opnd = py;
      2'd2:    opnd = pz;
      default: opnd = ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= cmd.mac_step;
    end
    prod   <= mat[cmd.mac_k] * opnd;
    prod_k <= cmd.mac_k;
  end

  // Row accumulation with floored products, row saturated to 32 bits
  logic signed [63:0] acc, acc_sum;
  logic signed [31:0] row [4];
  logic signed [31:0] row_sat;

  always_comb begin
    acc_sum = ((prod_k[1:0] == 2'd0) ? 64'sd0 : acc) + (prod >>> F);
    if (acc_sum > S32_MAX) begin
      row_sat = 32'sh7fff_ffff;
    end else if (acc_sum < S32_MIN) begin
      row_sat = 32'sh8000_0000;
    end else begin
      row_sat = acc_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (prod_v) begin
      acc <= acc_sum;
      if (prod_k[1:0] == 2'd3) begin
        row[prod_k[3:2]] <= row_sat;
      end
    end
  end

  // Divide by w
  logic signed [NW-1:0] div_num;
  logic signed [QW-1:0] q;
  logic                 div_busy, div_done;
  assign div_num = {(cmd.axis ? row[1] : row[0]), {F{1'b0}}};

  wep_divider #(.NW(NW), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_num), .divisor(row[3]),
    .busy(div_busy), .done(div_done), .quotient(q)
  );

  // Viewport multiply
  logic signed [TW-1:0] t;
  logic signed [13:0]   dim;
  logic signed [PW-1:0] pix_prod;
  assign t   = cmd.axis ? (TW'(ONE) - TW'(q)) : (TW'(q) + TW'(ONE));
  assign dim = $signed({1'b0, (cmd.axis ? win_h : win_w)});

  always_ff @(posedge clk) begin
    if (cmd.pix_mul) begin
      pix_prod <= PW'(t) * PW'(dim);
    end
  end

  // Truncating shift by 2*one, then saturate to 16 bits
  logic signed [PW-1:0] pix_sh;
  logic signed [15:0]   pix;
  always_comb begin
    pix_sh = (pix_prod + (pix_prod[PW-1] ? BIAS : PW'(0))) >>> (F + 1);
    if (pix_sh > PIX_MAX) begin
      pix = 16'sh7fff;
    end else if (pix_sh < PIX_MIN) begin
      pix = 16'sh8000;
    end else begin
      pix = pix_sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_store) begin
      case ({cmd.ep, cmd.axis})
        2'b00:   start_x <= pix;
        2'b01:   start_y <= pix;
        2'b10:   end_x   <= pix;
        default: end_y   <= pix;
      endcase
    end
    if (cmd.emit) begin
      line_color <= it_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else begin
      line_valid <= cmd.emit;
    end
  end

  // Status to controller
  assign status.mode     = it_mode;
  assign status.idx1_ok  = (32'(it_i1) < MAX_POINTS);
  assign status.idx2_ok  = (32'(it_i2) < MAX_POINTS);
  assign status.reject   = row[2][31] || (row[3] == 32'sd0);
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
endmodule

/* design/wep_control.sv */
// Controller state machine sequencing loads, transforms, divisions and pixel steps.
// Depends on wep_pkg and the assertion header.
`include "wireframe_edge_projector_assert.svh"
module wep_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  wep_pkg::wep_status_t status,
  output wep_pkg::wep_cmd_t    cmd
);
  import wep_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_RDPT   = 11'b000_0000_0100,
    S_MAC    = 11'b000_0000_1000,
    S_DRAIN  = 11'b000_0001_0000,
    S_CHECK  = 11'b000_0010_0000,
    S_DSTART = 11'b000_0100_0000,
    S_DIV    = 11'b000_1000_0000,
    S_PMUL   = 11'b001_0000_0000,
    S_PSAT   = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [3:0] k, k_next;
  logic       ep, ep_next;
  logic       axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      ep    <= 1'b0;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      ep    <= ep_next;
      axis  <= axis_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    k_next     = k;
    ep_next    = ep;
    axis_next  = axis;
    cmd        = '0;
    cmd.ep     = ep;
    cmd.axis   = axis;
    cmd.mac_k  = k;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        ep_next    = 1'b0;
        state_next = S_IDLE;
        case (status.mode)
          MODE_LOAD_POINT:  cmd.store_point  = status.idx1_ok;
          MODE_LOAD_MATRIX: cmd.store_matrix = 1'b1;
          MODE_DRAW_EDGE: begin
            if (status.idx1_ok && status.idx2_ok) begin
              state_next = S_RDPT;
            end
          end
          default: ;
        endcase
      end
      S_RDPT: begin
        cmd.rd_point = 1'b1;
        k_next       = '0;
        state_next   = S_MAC;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        k_next       = k + 1'b1;
        if (k == 4'd15) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_CHECK;
      S_CHECK: begin
        axis_next  = 1'b0;
        state_next = status.reject ? S_IDLE : S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd.pix_mul = 1'b1;
        state_next  = S_PSAT;
      end
      S_PSAT: begin
        cmd.pix_store = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_DSTART;
        end else if (!ep) begin
          ep_next    = 1'b1;
          state_next = S_RDPT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `WEP_ASSERT(a_accept_decodes, (state == S_IDLE && start) |=> (state == S_DECODE), "accepted transaction not decoded")
  `WEP_ASSERT(a_emit_returns_idle, cmd.emit |=> !busy, "not idle after emitting a line")
  `WEP_ASSERT(a_div_not_restarted, cmd.div_start |-> !status.div_busy, "divider restarted while busy")
  `WEP_ASSERT(a_div_done_waited, status.div_done |-> (state == S_DIV), "division finished outside wait state")
endmodule

/* design/wireframe_edge_projector.sv */
// Wireframe edge projector: loads points and matrix entries, and draws edges from Q16.16 points
// (at COORD_FRAC_BITS = 16). Edge cost is set by the 16-step shared matrix multiplier and the
// bit-serial divider, run per endpoint.
// One transaction at a time; busy is high from acceptance until the line strobe, load or rejection.
// rst is synchronous: config and matrix return to defaults, point stores are undefined until written.
// Results are strobed on line_valid for one cycle and cannot be stalled.
module wireframe_edge_projector #(
  parameter int MAX_POINTS      = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we,
  input  logic [wep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wep_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                     mode,
  input  logic [7:0]                     first_index,
  input  logic [7:0]                     second_index,
  input  logic signed [31:0]             coord_x,
  input  logic signed [31:0]             coord_y,
  input  logic signed [31:0]             coord_z,
  input  logic signed [31:0]             matrix_value,
  input  logic [31:0]                    edge_color,
  output logic                           line_valid,
  output logic signed [15:0]             start_x,
  output logic signed [15:0]             start_y,
  output logic signed [15:0]             end_x,
  output logic signed [15:0]             end_y,
  output logic [31:0]                    line_color
);
  import wep_pkg::*;

  wep_cmd_t    cmd;
  wep_status_t status;

  wep_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mode(mode), .first_index(first_index), .second_index(second_index),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .matrix_value(matrix_value), .edge_color(edge_color),
    .cmd(cmd), .status(status),
    .line_valid(line_valid), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .line_color(line_color)
  );

  wep_control u_ctl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .status(status), .cmd(cmd)
  );
endmodule

/* dv/tb.sv */
// Self-checking testbench for wireframe_edge_projector: random and directed point,
// matrix and edge transactions checked against an in-bench projection predictor.
// Depends on wep_pkg and the wireframe_edge_projector RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wep_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int EDGE_LAT = 400;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  idx1;
    logic [7:0]  idx2;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] mval;
    logic [31:0] color;
  } edge_cmd_t;

  typedef struct packed {
    logic [15:0] sx0;
    logic [15:0] sy0;
    logic [15:0] sx1;
    logic [15:0] sy1;
    logic [31:0] color;
  } line_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic [1:0] mode = '0;
  logic [7:0] first_index = '0;
  logic [7:0] second_index = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic signed [31:0] matrix_value = '0;
  logic [31:0] edge_color = '0;
  logic line_valid;
  logic signed [15:0] start_x, start_y, end_x, end_y;
  logic [31:0] line_color;

  wireframe_edge_projector dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint pt_x [256];
  longint pt_y [256];
  longint pt_z [256];
  longint proj_m [16];
  longint win_w = 1680, win_h = 1050;
  longint off_x = 0, off_y = 0, off_z = 0;

  // which points will be loaded by queued items (stimulus-side view)
  bit pt_loaded_q [256];

  edge_cmd_t pending_cmds [$];
  line_t     expected_lines [$];
  int errors = 0;
  int lines_seen = 0;
  int edges_sent = 0;
  int send_idle_pct = 32;
  longint cycle_count = 0;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_q(longint v);
    return v >>> FRAC;  // arithmetic shift floors
  endfunction

  function automatic longint row_xf(int r, longint x, longint y, longint z);
    longint acc;
    acc = floor_q(proj_m[r*4] * x) + floor_q(proj_m[r*4+1] * y)
        + floor_q(proj_m[r*4+2] * z) + proj_m[r*4+3];
    return sat(acc, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // Projects one stored point to pixels; returns 0 when the point is rejected
  function automatic bit project_point(int i, output longint sx, output longint sy);
    longint cx, cy, cz, cw, qx, qy;
    cx = row_xf(0, pt_x[i], pt_y[i], pt_z[i]);
    cy = row_xf(1, pt_x[i], pt_y[i], pt_z[i]);
    cz = row_xf(2, pt_x[i], pt_y[i], pt_z[i]);
    cw = row_xf(3, pt_x[i], pt_y[i], pt_z[i]);
    sx = 0;
    sy = 0;
    if (cz < 0 || cw == 0) return 1'b0;
    qx = (cx * ONE) / cw;
    qy = (cy * ONE) / cw;
    sx = sat(((qx + ONE) * win_w) / (2 * ONE), -32768, 32767);
    sy = sat(((ONE - qy) * win_h) / (2 * ONE), -32768, 32767);
    return 1'b1;
  endfunction

  // Applies one accepted transaction to the predictor
  task automatic predict_item(edge_cmd_t c);
    longint sx0, sy0, sx1, sy1;
    line_t l;
    case (c.mode)
      MODE_LOAD_POINT: begin
        pt_x[c.idx1] = sat(longint'($signed(c.px)) + off_x, -64'sd2147483648, 64'sd2147483647);
        pt_y[c.idx1] = sat(longint'($signed(c.py)) + off_y, -64'sd2147483648, 64'sd2147483647);
        pt_z[c.idx1] = sat(longint'($signed(c.pz)) + off_z, -64'sd2147483648, 64'sd2147483647);
      end
      MODE_LOAD_MATRIX: if (c.idx1 < 16) proj_m[c.idx1] = longint'($signed(c.mval));
      MODE_DRAW_EDGE: begin
        if (project_point(c.idx1, sx0, sy0) && project_point(c.idx2, sx1, sy1)) begin
          l.sx0 = sx0[15:0];
          l.sy0 = sy0[15:0];
          l.sx1 = sx1[15:0];
          l.sy1 = sy1[15:0];
          l.color = c.color;
          expected_lines.push_back(l);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  // driver: one transaction per accept, random gaps
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (start && !busy) begin
        predict_item(pending_cmds.pop_front());
      end
      if (!(start && busy) && pending_cmds.size() > 0
          && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        mode <= pending_cmds[0].mode;
        first_index <= pending_cmds[0].idx1;
        second_index <= pending_cmds[0].idx2;
        coord_x <= pending_cmds[0].px;
        coord_y <= pending_cmds[0].py;
        coord_z <= pending_cmds[0].pz;
        matrix_value <= pending_cmds[0].mval;
        edge_color <= pending_cmds[0].color;
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // Note: the item at queue head is popped only once accepted; the driver keeps
  // start high while busy so the same head item stays presented.

  // monitor: compare each strobed line with the oldest expectation
  always @(posedge clk) begin
    line_t w;
    if (!rst && line_valid) begin
      lines_seen++;
      if (expected_lines.size() == 0) begin
        report_mismatch("unexpected line", 1, 0);
      end else begin
        w = expected_lines.pop_front();
        if (start_x !== w.sx0) report_mismatch("start_x", start_x, w.sx0);
        if (start_y !== w.sy0) report_mismatch("start_y", start_y, w.sy0);
        if (end_x !== w.sx1) report_mismatch("end_x", end_x, w.sx1);
        if (end_y !== w.sy1) report_mismatch("end_y", end_y, w.sy1);
        if (line_color !== w.color) report_mismatch("line_color", line_color, w.color);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic edge_cmd_t mk(logic [1:0] m, logic [7:0] a, logic [7:0] b,
                                   logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [31:0] v, logic [31:0] c);
    edge_cmd_t e;
    e.mode = m; e.idx1 = a; e.idx2 = b; e.px = x; e.py = y; e.pz = z;
    e.mval = v; e.color = c;
    return e;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC);
    endcase
  endfunction

  function automatic logic [31:0] rand_mval();
    case ($urandom_range(6))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'(ONE);
      default: return $signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC);
    endcase
  endfunction

  // picks a loaded point index, biased toward a small working set
  function automatic logic [7:0] loaded_index();
    int i;
    for (int t = 0; t < 50; t++) begin
      i = $urandom_range(1) ? $urandom_range(15) : $urandom_range(255);
      if (pt_loaded_q[i]) return i[7:0];
    end
    return 8'd0;
  endfunction

  task automatic queue_cmd(edge_cmd_t e);
    if (e.mode == MODE_LOAD_POINT) pt_loaded_q[e.idx1] = 1'b1;
    if (e.mode == MODE_DRAW_EDGE) edges_sent++;
    pending_cmds.push_back(e);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || expected_lines.size() > 0 || busy || start)
      @(posedge clk);
    repeat (EDGE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW_WIDTH: win_w = val[12:0];
      CFG_WINDOW_HEIGHT: win_h = val[12:0];
      CFG_OFFSET_X: off_x = longint'($signed(val));
      CFG_OFFSET_Y: off_y = longint'($signed(val));
      CFG_OFFSET_Z: off_z = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 30)
        queue_cmd(mk(MODE_LOAD_POINT, $urandom_range(1) ? $urandom_range(15) : $urandom(),
                     $urandom(), rand_coord(), rand_coord(), rand_coord(), $urandom(),
                     $urandom()));
      else if (r < 45)
        queue_cmd(mk(MODE_LOAD_MATRIX, $urandom_range(3) ? $urandom_range(15) : $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom(), rand_mval(), $urandom()));
      else if (r < 95)
        queue_cmd(mk(MODE_DRAW_EDGE, loaded_index(), loaded_index(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom()));
      else
        queue_cmd(mk(MODE_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom()));
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) proj_m[i] = (i % 5 == 0) ? ONE : 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, each mode, rejection, unused mode, out-of-range matrix index
    queue_cmd(mk(MODE_LOAD_POINT, 0, 0, 0, 0, 32'(ONE), 0, 0));
    queue_cmd(mk(MODE_LOAD_POINT, 255, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0));
    queue_cmd(mk(MODE_LOAD_POINT, 1, 0, 32'(ONE/2), 32'(-ONE/2), 32'(-ONE), 0, 0));
    queue_cmd(mk(MODE_DRAW_EDGE, 0, 255, 0, 0, 0, 0, 32'hFFFFFFFF));
    queue_cmd(mk(MODE_DRAW_EDGE, 0, 1, 0, 0, 0, 0, 32'h00000000));  // z below zero
    queue_cmd(mk(MODE_UNUSED, 8'hFF, 8'hFF, '1, '1, '1, '1, '1));
    queue_cmd(mk(MODE_LOAD_MATRIX, 16, 0, 0, 0, 0, 32'h12345678, 0));
    queue_cmd(mk(MODE_LOAD_MATRIX, 14, 0, 0, 0, 0, 32'(ONE), 0));  // w follows z
    queue_cmd(mk(MODE_LOAD_MATRIX, 15, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_LOAD_MATRIX, 3, 0, 0, 0, 0, 32'h7FFFFFFF, 0));
    queue_cmd(mk(MODE_DRAW_EDGE, 0, 255, 0, 0, 0, 0, 32'hA5A5A5A5));
    queue_cmd(mk(MODE_LOAD_POINT, 2, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_DRAW_EDGE, 0, 2, 0, 0, 0, 0, 32'h5A5A5A5A));  // w zero
    queue_cmd(mk(MODE_LOAD_MATRIX, 3, 0, 0, 0, 0, 32'h80000000, 0));
    queue_cmd(mk(MODE_DRAW_EDGE, 255, 0, 0, 0, 0, 0, 32'h1));
    queue_cmd(mk(MODE_LOAD_MATRIX, 3, 0, 0, 0, 0, 0, 0));
    random_phase(80);

    // hold off until drained, then reconfigure
    wait_idle();
    write_reg(CFG_WINDOW_WIDTH, 32'd4096);
    write_reg(CFG_WINDOW_HEIGHT, 32'd1);
    write_reg(CFG_OFFSET_X, 32'h7FFFFFFF);
    write_reg(CFG_OFFSET_Y, 32'h80000000);
    write_reg(CFG_OFFSET_Z, 32'(ONE));
    send_idle_pct = 82;
    random_phase(150);
    wait_idle();

    write_reg(CFG_WINDOW_WIDTH, 32'd0);
    write_reg(CFG_WINDOW_HEIGHT, 32'hFFFFFFFF);
    write_reg(CFG_OFFSET_X, 32'(-3 * ONE));
    write_reg(CFG_OFFSET_Y, 32'(ONE / 4));
    write_reg(CFG_OFFSET_Z, 32'h80000000);
    random_phase(120);
    wait_idle();

    write_reg(CFG_WINDOW_WIDTH, 32'd1);
    write_reg(CFG_WINDOW_HEIGHT, 32'd4096);
    write_reg(CFG_OFFSET_X, 0);
    write_reg(CFG_OFFSET_Y, 0);
    write_reg(CFG_OFFSET_Z, 32'(2 * ONE));
    send_idle_pct = 0;
    random_phase(150);
    wait_idle();

    write_reg(CFG_WINDOW_WIDTH, 32'd1680);
    write_reg(CFG_WINDOW_HEIGHT, 32'd1050);
    write_reg(CFG_OFFSET_Z, 0);
    random_phase(135);
    wait_idle();

    $display("covered %0d edge transactions, %0d lines drawn, five register settings",
             edges_sent, lines_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
